### rtl/lphs_pkg.sv
// Package for the linear probing hash set: request codes, bucket marks,
// request and result word layouts, datapath command and status structs. No dependencies.
package lphs_pkg;

  localparam int unsigned KeyW  = 31;
  localparam int unsigned SizeW = 11;
  localparam int unsigned SlotW = 10;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_ERASE  = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MARK_NEVER = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_GONE  = 2'd2,
    MARK_RSVD  = 2'd3
  } mark_e;

  // Request and result word layouts
  typedef struct packed {
    req_e            req_type;
    logic [KeyW-1:0] key;
  } req_word_t;

  typedef struct packed {
    logic             ok;
    logic [SlotW-1:0] slot;
    logic [SizeW-1:0] used_count;
  } res_word_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // capture request word, start modulo
    logic mod_step;  // one restoring-division step
    logic rd;        // issue bucket read at current index
    logic adv;       // advance index with wrap
    logic wr_live;   // write key, mark live at current index
    logic wr_gone;   // mark current index deleted
    logic clr;       // clear sweep write at sweep index
    logic clr_adv;   // advance sweep index
    logic res_hit;   // result ok=1 slot=index
    logic res_ok;    // result ok=1 slot=0
    logic res_miss;  // result ok=0 slot=0
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic mod_done;
    logic live;      // read mark is live
    logic never;     // read mark is never used
    logic match;     // read key equals request key
    logic nxt_home;  // advanced index equals home
    logic last;      // probe count reached table size
    logic clr_last;  // sweep at last entry
    req_e req;
  } sts_t;

endpackage

### rtl/lphs_if.sv
// Valid/ready channel interface used by both request and result words.
// Depends on nothing; payload type given as a parameter.
interface lphs_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/lphs_dpath.sv
// Datapath of the hash set: bucket memories, modulo unit, probe index,
// live counter and result register. Depends on lphs_pkg.
module lphs_dpath import lphs_pkg::*; #(
  parameter int unsigned Depth = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SizeW-1:0] table_size_i,
  input  logic [1:0]       req_type_i,
  input  logic [KeyW-1:0]  key_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             ok_o,
  output logic [SlotW-1:0] slot_o,
  output logic [SizeW-1:0] used_count_o
);
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW   = $clog2(Depth + 1);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned ModSteps = KeyW;
  localparam int unsigned MStepW = $clog2(ModSteps + 1);

  logic [KeyW-1:0]  key_mem [Depth];
  logic [1:0]       mark_mem [Depth];

  logic [KeyW-1:0]  key_q, rem_sh_q;
  logic [NW-1:0]    rem_q;
  logic [MStepW-1:0] mstep_q;
  req_e             req_q;
  logic [NW-1:0]    n_q;
  logic [IdxW-1:0]  idx_q, home_q, clr_q;
  logic [NW-1:0]    probe_q;
  logic [KeyW-1:0]  rkey_q;
  logic [1:0]       rmark_q;
  logic [CntW-1:0]  live_q;
  logic             ok_q;
  logic [SlotW-1:0] slot_q;

  // Effective table size: zero becomes one, saturate at depth
  logic [NW-1:0] n_eff;
  always_comb begin
    if (table_size_i == '0) n_eff = NW'(1);
    else if ({21'd0, table_size_i} > 32'(Depth)) n_eff = NW'(Depth);
    else n_eff = NW'(table_size_i);
  end

  // Restoring division remainder, one key bit per step
  logic [NW:0] rem_try;
  always_comb rem_try = {rem_q, rem_sh_q[KeyW-1]};

  logic [IdxW-1:0] idx_nxt;
  always_comb begin
    if ({{(32-IdxW){1'b0}}, idx_q} + 32'd1 >= {{(32-NW){1'b0}}, n_q}) idx_nxt = '0;
    else idx_nxt = idx_q + IdxW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstep_q <= '0;
      live_q  <= '0;
      clr_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        mstep_q <= '0;
      end else if (cmd_i.mod_step) begin
        mstep_q <= mstep_q + MStepW'(1);
      end
      if (cmd_i.clr_adv) clr_q <= clr_q + IdxW'(1);
      if (cmd_i.wr_live) live_q <= live_q + CntW'(1);
      else if (cmd_i.wr_gone && live_q != '0) live_q <= live_q - CntW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q    <= key_i;
      rem_sh_q <= key_i;
      rem_q    <= '0;
      req_q    <= req_e'(req_type_i);
      n_q      <= n_eff;
    end else if (cmd_i.mod_step) begin
      rem_sh_q <= rem_sh_q << 1;
      if (rem_try >= {1'b0, n_q}) rem_q <= NW'(rem_try - {1'b0, n_q});
      else rem_q <= NW'(rem_try);
      if (mstep_q == MStepW'(ModSteps - 1)) begin
        idx_q   <= (rem_try >= {1'b0, n_q}) ? IdxW'(rem_try - {1'b0, n_q}) : IdxW'(rem_try);
        home_q  <= (rem_try >= {1'b0, n_q}) ? IdxW'(rem_try - {1'b0, n_q}) : IdxW'(rem_try);
        probe_q <= '0;
      end
    end else if (cmd_i.adv) begin
      idx_q   <= idx_nxt;
      probe_q <= probe_q + NW'(1);
    end
    if (cmd_i.res_hit || cmd_i.res_ok || cmd_i.res_miss) begin
      ok_q   <= cmd_i.res_hit || cmd_i.res_ok;
      slot_q <= cmd_i.res_hit ? SlotW'(idx_q) : '0;
    end
  end

  // Bucket memories, one read or write a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) mark_mem[clr_q] <= MARK_NEVER;
    else if (cmd_i.wr_live) begin
      mark_mem[idx_q] <= MARK_LIVE;
      key_mem[idx_q]  <= key_q;
    end else if (cmd_i.wr_gone) mark_mem[idx_q] <= MARK_GONE;
    if (cmd_i.rd) begin
      rmark_q <= mark_mem[idx_q];
      rkey_q  <= key_mem[idx_q];
    end
  end

  always_comb begin
    sts_o.mod_done = (mstep_q == MStepW'(ModSteps));
    sts_o.live     = (rmark_q == MARK_LIVE);
    sts_o.never    = (rmark_q == MARK_NEVER);
    sts_o.match    = (rkey_q == key_q);
    sts_o.nxt_home = (idx_nxt == home_q);
    sts_o.last     = (probe_q + NW'(1) >= n_q);
    sts_o.clr_last = (clr_q == IdxW'(Depth - 1));
    sts_o.req      = req_q;
  end

  assign ok_o         = ok_q;
  assign slot_o       = slot_q;
  assign used_count_o = SizeW'(live_q);
endmodule

### rtl/lphs_ctrl.sv
// Controller of the hash set: clearing pass, modulo, probe walk, result.
// Depends on lphs_pkg.
module lphs_ctrl import lphs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MOD, ST_READ, ST_WAIT, ST_EVAL, ST_OUT, ST_STEP, ST_CHECK
  } state_e;

  state_e state_q;
  logic   ovalid_q;

  // A new word is taken only once the previous result word has left
  assign in_ready_o  = (state_q == ST_IDLE) && !ovalid_q;
  assign out_valid_o = ovalid_q;

  // Command decode per state
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        cmd_o.clr_adv = 1'b1;
      end
      ST_IDLE:  cmd_o.load = in_valid_i && !ovalid_q;
      ST_MOD:   cmd_o.mod_step = !sts_i.mod_done;
      ST_READ:  cmd_o.rd = 1'b1;
      ST_EVAL: begin
        case (sts_i.req)
          REQ_INSERT: begin
            if (!sts_i.live) begin
              cmd_o.wr_live = 1'b1;
              cmd_o.res_hit = 1'b1;
            end else if (sts_i.last) cmd_o.res_miss = 1'b1;
            else cmd_o.adv = 1'b1;
          end
          REQ_ERASE: begin
            cmd_o.wr_gone = sts_i.live && sts_i.match;
            cmd_o.adv = 1'b1;
          end
          REQ_FIND: begin
            if (sts_i.live && sts_i.match) cmd_o.res_hit = 1'b1;
            else cmd_o.adv = 1'b1;
          end
          default: cmd_o.res_miss = 1'b1;
        endcase
      end
      ST_STEP: begin
        // after advancing, read next mark to decide whether to go on
        cmd_o.rd = 1'b1;
      end
      ST_WAIT: begin
        if (sts_i.req == REQ_ERASE) cmd_o.res_ok = 1'b1;
        else cmd_o.res_miss = 1'b1;
      end
      default: ;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ovalid_q <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: if (sts_i.clr_last) state_q <= ST_IDLE;
        ST_IDLE:  if (in_valid_i && !ovalid_q) state_q <= ST_MOD;
        ST_MOD: begin
          if (sts_i.mod_done) begin
            if (sts_i.req == REQ_NOP) begin
              state_q <= ST_EVAL;
            end else state_q <= ST_READ;
          end
        end
        ST_READ:  state_q <= ST_EVAL;
        ST_EVAL: begin
          if (cmd_o.res_hit || cmd_o.res_miss) begin
            state_q <= ST_OUT;
          end else if (sts_i.req == REQ_INSERT) state_q <= ST_READ;
          else if (sts_i.nxt_home) state_q <= ST_WAIT;
          else state_q <= ST_STEP;
        end
        ST_STEP:  state_q <= ST_CHECK;
        // walk stops at a never used bucket, else evaluate the word just read
        ST_CHECK: begin
          if (sts_i.never) state_q <= ST_WAIT;
          else state_q <= ST_EVAL;
        end
        ST_WAIT:  state_q <= ST_OUT;
        ST_OUT: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default:  state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

### rtl/linear_probe_hash_set.sv
// Linear probing hash set, top level. A request runs the modulo of its key by the
// table size, then a bucket read, evaluate and output; a no-op skips the read.
// Further buckets are read in turn: an insert ends at the first bucket not live
// or when the table is full, and an erase or find miss ends when the walk wraps
// home or stops at a never used bucket.
// One request at a time: the next word is taken the cycle after the result word
// is accepted. After reset a clearing pass marks all buckets never used; no
// request is taken until it ends.
// Depends on lphs_pkg, lphs_if, lphs_ctrl and lphs_dpath.
module linear_probe_hash_set import lphs_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  lphs_if.sink             req_if,
  lphs_if.source           res_if
);
  logic [SizeW-1:0] table_size_q;
  cmd_t cmd;
  sts_t sts;
  logic res_ok;
  logic [SlotW-1:0] res_slot;
  logic [SizeW-1:0] res_used;

  // Table size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) table_size_q <= SizeW'(1021);
    else if (cfg_we_i) table_size_q <= cfg_wdata_i;
  end

  lphs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_if.valid),
    .in_ready_o (req_if.ready),
    .out_valid_o(res_if.valid),
    .out_ready_i(res_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lphs_dpath #(.Depth(DEPTH)) u_dpath (
    .clk_i, .rst_ni,
    .table_size_i(table_size_q),
    .req_type_i  (req_if.data.req_type),
    .key_i       (req_if.data.key),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .ok_o        (res_ok),
    .slot_o      (res_slot),
    .used_count_o(res_used)
  );

  assign res_if.data.ok         = res_ok;
  assign res_if.data.slot       = res_slot;
  assign res_if.data.used_count = res_used;
endmodule
